/* sv/avt_pkg.sv */
package avt_pkg;

  localparam int FracBitsDefault   = 16;
  localparam int CoordWidthDefault = 32;

  // Every coefficient slot and every port coordinate is 32 bits wide.
  localparam int FieldWidth = 32;
  localparam int NumRows    = 3;
  localparam int NumCols    = 4;
  localparam int NumRegs    = 6;
  localparam int RegWidth   = 64;
  localparam int CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    ROW0_COLS01 = 3'd0,
    ROW0_COLS23 = 3'd1,
    ROW1_COLS01 = 3'd2,
    ROW1_COLS23 = 3'd3,
    ROW2_COLS01 = 3'd4,
    ROW2_COLS23 = 3'd5
  } cfg_reg_e;

  // Reset matrix is the identity for the default Q16.16 format.
  localparam logic [RegWidth-1:0] RegReset [NumRegs] = '{
    64'd65536,
    64'd0,
    64'd281474976710656,
    64'd0,
    64'd0,
    64'd65536
  };

  typedef struct packed {
    logic signed [FieldWidth-1:0] x_in;
    logic signed [FieldWidth-1:0] y_in;
    logic signed [FieldWidth-1:0] z_in;
  } vertex_in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] x_out;
    logic signed [FieldWidth-1:0] y_out;
    logic signed [FieldWidth-1:0] z_out;
    logic                         overflow;
  } vertex_out_t;

  // What one row lane hands to the merge stage.
  typedef struct packed {
    logic signed [FieldWidth-1:0] value;
    logic                         ovf;
  } lane_res_t;

  typedef logic [NumCols-1:0][FieldWidth-1:0] coef_row_t;

endpackage

/* sv/avt_coef_regs.sv */
module avt_coef_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [avt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [avt_pkg::RegWidth-1:0]        cfg_data_i,
  output avt_pkg::coef_row_t [avt_pkg::NumRows-1:0] coef_o
);
  import avt_pkg::*;

  logic [RegWidth-1:0] regs_q [NumRegs];
  logic [RegWidth-1:0] regs_d [NumRegs];

  always_comb begin
    regs_d = regs_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i)) inside
        ROW0_COLS01, ROW0_COLS23, ROW1_COLS01,
        ROW1_COLS23, ROW2_COLS01, ROW2_COLS23: regs_d[cfg_index_i] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= RegReset[i];
      end
    end else begin
      regs_q <= regs_d;
    end
  end

  // Two coefficients per register: even column in the low half.
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumCols; c++) begin
        if (c % 2 == 1) begin
          coef_o[r][c] = regs_q[r * 2 + c / 2][RegWidth-1:FieldWidth];
        end else begin
          coef_o[r][c] = regs_q[r * 2 + c / 2][FieldWidth-1:0];
        end
      end
    end
  end

endmodule

/* sv/avt_lane.sv */
module avt_lane #(
  parameter int FRAC_BITS   = avt_pkg::FracBitsDefault,
  parameter int COORD_WIDTH = avt_pkg::CoordWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  avt_pkg::vertex_in_t pt_i,
  input  avt_pkg::coef_row_t  coef_i,
  output logic                valid_o,
  output avt_pkg::lane_res_t  res_o
);
  import avt_pkg::*;

  localparam int PW = 2 * COORD_WIDTH;   // exact product
  localparam int SW = PW + 2;            // exact sum of three products
  localparam int QW = SW - FRAC_BITS;    // after the floor shift
  localparam int RW = QW + 1;            // after adding the translation

  logic signed [COORD_WIDTH-1:0] pt_s [3];
  logic signed [COORD_WIDTH-1:0] cf_s [NumCols];
  logic signed [PW-1:0]          prod_d [3];
  logic signed [PW-1:0]          prod_q [3];
  logic signed [SW-1:0]          sum_d, sum_q;
  logic signed [QW-1:0]          quot;
  logic signed [RW-1:0]          acc;
  logic                          acc_ovf;
  logic signed [COORD_WIDTH-1:0] sat;
  lane_res_t                     res_d, res_q;
  logic                          v1_q, v2_q, v3_q;

  assign pt_s[0] = $signed(pt_i.x_in[COORD_WIDTH-1:0]);
  assign pt_s[1] = $signed(pt_i.y_in[COORD_WIDTH-1:0]);
  assign pt_s[2] = $signed(pt_i.z_in[COORD_WIDTH-1:0]);

  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      cf_s[c] = $signed(coef_i[c][COORD_WIDTH-1:0]);
    end
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = cf_s[c] * pt_s[c];
    end
  end

  // Stage 1: three multipliers. Stage 2: exact sum. Stage 3: shift, offset, clamp.
  assign sum_d = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);

  // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
  assign quot = sum_q[SW-1:FRAC_BITS];
  assign acc  = RW'(quot) + RW'(cf_s[3]);

  assign acc_ovf = !((&acc[RW-1:COORD_WIDTH-1]) || !(|acc[RW-1:COORD_WIDTH-1]));
  assign sat = acc_ovf ? {acc[RW-1], {(COORD_WIDTH-1){!acc[RW-1]}}}
                       : acc[COORD_WIDTH-1:0];

  assign res_d.value = FieldWidth'(sat);
  assign res_d.ovf   = acc_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

/* sv/avt_merge.sv */
module avt_merge (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  avt_pkg::lane_res_t [avt_pkg::NumRows-1:0] res_i,
  output logic                                      done_o,
  output avt_pkg::vertex_out_t                      result_o
);
  import avt_pkg::*;

  logic        done_q;
  vertex_out_t result_d, result_q;

  always_comb begin
    result_d.x_out    = res_i[0].value;
    result_d.y_out    = res_i[1].value;
    result_d.z_out    = res_i[2].value;
    result_d.overflow = res_i[0].ovf | res_i[1].ovf | res_i[2].ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

/* sv/affine_vertex_transform.sv */
// Channel    Direction  Handshake                   Payload
// point      in         start_i / busy_o            point_i  (x_in, y_in, z_in)
// result     out        done_o, one-cycle strobe    result_o (x_out, y_out, z_out, overflow)
// config     in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// A point is taken on every clock edge with start_i high; busy_o stays low.
// done_o follows the accepting edge through the lane and merge registers, with the
// result valid while it is high. There is one register each for the row multipliers,
// the product sum, the shift, offset and clamp, and the merge. Throughput is one point
// per clock. Reset loads the identity matrix and empties the pipeline.
// The receiver cannot stall, so nothing ever holds the pipeline.
module affine_vertex_transform #(
  parameter int FRAC_BITS   = avt_pkg::FracBitsDefault,
  parameter int COORD_WIDTH = avt_pkg::CoordWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  avt_pkg::vertex_in_t          point_i,
  output logic                         done_o,
  output avt_pkg::vertex_out_t         result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [avt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [avt_pkg::RegWidth-1:0] cfg_data_i
);
  import avt_pkg::*;

  // Clamp values as they look on the 32-bit result ports.
  localparam logic [FieldWidth-1:0] SatMax =
    FieldWidth'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [FieldWidth-1:0] SatMin = ~SatMax;

  coef_row_t [NumRows-1:0] coef;
  lane_res_t [NumRows-1:0] lane_res;
  logic      [NumRows-1:0] lane_valid;
  logic                    accept;

  // The pipeline never stalls, so a new point is always welcome, and the
  // coefficient registers take a write in any cycle.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  avt_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // One lane per matrix row; all three see the same point in the same cycle.
  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    avt_lane #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (accept),
      .pt_i    (point_i),
      .coef_i  (coef[r]),
      .valid_o (lane_valid[r]),
      .res_o   (lane_res[r])
    );
  end

  // The lanes run in lockstep; the merge collects their values and ORs
  // the per-row saturation flags into one overflow bit.
  avt_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (lane_valid[0]),
    .res_i    (lane_res),
    .done_o   (done_o),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  // Every result strobe stems from an accepted point that has passed the lane and merge registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobe without a matching accepted point");

  // The lanes must never drift apart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid == '0) || (lane_valid == '1))
    else $error("row lanes out of step");

  // A raised overflow flag means at least one coordinate sits at a clamp value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.overflow) |->
      (result_o.x_out == SatMax || result_o.x_out == SatMin ||
       result_o.y_out == SatMax || result_o.y_out == SatMin ||
       result_o.z_out == SatMax || result_o.z_out == SatMin))
    else $error("overflow flagged with no clamped coordinate");

  // A write to the first register lands in row 0, columns 0 and 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == ROW0_COLS01) |=>
      (coef[0][0] == $past(cfg_data_i[FieldWidth-1:0]) &&
       coef[0][1] == $past(cfg_data_i[RegWidth-1:FieldWidth])))
    else $error("coefficient write not reflected in row 0");
`endif

endmodule
